// ===== sv/rgbfte_pkg.sv =====
package rgbfte_pkg;

	// Frame store geometry and channel precision
	localparam int MAX_WIDTH    = 512;
	localparam int MAX_HEIGHT   = 512;
	localparam int CHANNEL_BITS = 16;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PIX_W  = 3 * CHANNEL_BITS;

	// Gray: floor(sum / 3) as (sum * GRAY_RECIP) >> GRAY_SHIFT, exact for all sums
	localparam int SUM_W      = CHANNEL_BITS + 2;
	localparam int GRAY_SHIFT = SUM_W + 1;
	localparam int GRAY_RECIP = ((1 << GRAY_SHIFT) / 3) + 1;
	localparam int PROD_W     = SUM_W + GRAY_SHIFT;

	// Mode register codes
	localparam logic [2:0] MODE_NEG    = 3'd0;
	localparam logic [2:0] MODE_GRAY   = 3'd1;
	localparam logic [2:0] MODE_MIRROR = 3'd2;
	localparam logic [2:0] MODE_ROTATE = 3'd3;
	localparam logic [2:0] MODE_GROW   = 3'd4;
	localparam logic [2:0] MODE_SHRINK = 3'd5;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_MAXVAL = 2'd3;

	// Item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic [2:0]  mode;
		logic [9:0]  width;
		logic [9:0]  height;
		logic [15:0] max_value;
	} cfg_t;

	typedef struct packed {
		logic              access;
		logic              we;
		logic              oor;
		logic [ADDR_W-1:0] addr;
	} mem_req_t;

	typedef struct packed {
		logic       valid;
		logic       read;
		logic       oor;
		logic [2:0] mode;
	} ctl_t;

endpackage

// ===== sv/rgbfte_top.sv =====
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_ready  | func, row_pos, col_pos, red_in, green_in, blue_in
// output  | out       | out_valid / out_ready| red_out, green_out, blue_out, out_of_range
// config  | in/out    | psel, penable, pready| paddr[3:0], pwdata, prdata (regs at 4*i)
//
// One item per cycle while the output is not held; results pass through the store read, stage 2 and stage 3.
// The single frame store port does one access per item: a load writes in the accept
// cycle, a read reads there, so loads and reads stay in order with no forwarding.
// The store is not cleared; reset only clears valid flags and returns configuration to its defaults.
// When the output is held, the whole pipeline and the store port freeze together.
module rgb_frame_transform_engine_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [9:0]  row_pos,
	input  logic [9:0]  col_pos,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out,
	output logic        out_of_range,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CB = rgbfte_pkg::CHANNEL_BITS;

	rgbfte_pkg::cfg_t     cfg_q;
	rgbfte_pkg::mem_req_t req;
	rgbfte_pkg::ctl_t     ctl_s1;
	logic                 adv;
	logic                 acc;
	logic                 ram_en;
	logic [rgbfte_pkg::PIX_W-1:0] wdata;
	logic [rgbfte_pkg::PIX_W-1:0] rdata;
	logic                 cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= rgbfte_pkg::MODE_NEG;
			cfg_q.width     <= 10'd512;
			cfg_q.height    <= 10'd512;
			cfg_q.max_value <= 16'd255;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				rgbfte_pkg::REG_MODE:   cfg_q.mode      <= pwdata[2:0];
				rgbfte_pkg::REG_WIDTH:  cfg_q.width     <= pwdata[9:0];
				rgbfte_pkg::REG_HEIGHT: cfg_q.height    <= pwdata[9:0];
				rgbfte_pkg::REG_MAXVAL: cfg_q.max_value <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rgbfte_pkg::REG_MODE:   prdata = {29'd0, cfg_q.mode};
			rgbfte_pkg::REG_WIDTH:  prdata = {22'd0, cfg_q.width};
			rgbfte_pkg::REG_HEIGHT: prdata = {22'd0, cfg_q.height};
			rgbfte_pkg::REG_MAXVAL: prdata = {16'd0, cfg_q.max_value};
			default:                prdata = 32'd0;
		endcase
	end

	// whole pipeline moves when the output slot is free or being taken
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign acc      = in_valid && adv;

	rgbfte_addr u_addr (
		.func    (func),
		.row_pos (row_pos),
		.col_pos (col_pos),
		.cfg     (cfg_q),
		.req     (req)
	);

	// out-of-range items never touch the store
	assign ram_en = acc && req.access;
	assign wdata  = {blue_in[CB-1:0], green_in[CB-1:0], red_in[CB-1:0]};

	rgbfte_ram #(
		.WIDTH (rgbfte_pkg::PIX_W),
		.DEPTH (rgbfte_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (req.we),
		.addr  (req.addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// stage 1: control riding alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= acc;
			ctl_s1.read  <= (func == rgbfte_pkg::FUNC_READ);
			ctl_s1.oor   <= req.oor;
			ctl_s1.mode  <= cfg_q.mode;
		end
	end

	rgbfte_pix u_pix (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.ctl_s1       (ctl_s1),
		.rdata        (rdata),
		.max_value    (cfg_q.max_value),
		.out_valid    (out_valid),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.out_of_range (out_of_range)
	);

`ifndef SYNTHESIS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> red_out == 16'd0 && green_out == 16'd0
			&& blue_out == 16'd0)
		else $error("out of range result with non-zero channels");

	a_oor_no_access: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.oor |-> !ram_en)
		else $error("store accessed for out of range item");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid && !adv |=> ctl_s1.valid && $stable(ctl_s1))
		else $error("stage 1 lost its item during a stall");

	a_store_idle_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> !ram_en)
		else $error("store accessed while pipeline frozen");
`endif

endmodule

// ===== sv/rgbfte_ram.sv =====
module rgbfte_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 262144
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rgbfte_addr.sv =====
module rgbfte_addr (
	input  logic                 func,
	input  logic [9:0]           row_pos,
	input  logic [9:0]           col_pos,
	input  rgbfte_pkg::cfg_t     cfg,
	output rgbfte_pkg::mem_req_t req
);

	localparam logic [13:0] MAXW = 14'(rgbfte_pkg::MAX_WIDTH);
	localparam logic [13:0] MAXH = 14'(rgbfte_pkg::MAX_HEIGHT);

	logic [9:0]  eff_w;
	logic [9:0]  eff_h;
	logic [10:0] out_rows;
	logic [10:0] out_cols;
	logic [10:0] row_x;
	logic [10:0] col_x;
	logic [10:0] sr;
	logic [10:0] sc;
	logic        in_rng;
	logic [31:0] idx;

	always_comb begin
		eff_w = ({4'b0, cfg.width}  > MAXW) ? MAXW[9:0] : cfg.width;
		eff_h = ({4'b0, cfg.height} > MAXH) ? MAXH[9:0] : cfg.height;
		row_x = {1'b0, row_pos};
		col_x = {1'b0, col_pos};

		case (cfg.mode)
			rgbfte_pkg::MODE_NEG, rgbfte_pkg::MODE_GRAY, rgbfte_pkg::MODE_MIRROR: begin
				out_rows = {1'b0, eff_h};
				out_cols = {1'b0, eff_w};
			end
			rgbfte_pkg::MODE_ROTATE: begin
				out_rows = {1'b0, eff_w};
				out_cols = {1'b0, eff_h};
			end
			rgbfte_pkg::MODE_GROW: begin
				out_rows = {eff_h, 1'b0};
				out_cols = {eff_w, 1'b0};
			end
			rgbfte_pkg::MODE_SHRINK: begin
				out_rows = ({1'b0, eff_h} + 11'd1) >> 1;
				out_cols = ({1'b0, eff_w} + 11'd1) >> 1;
			end
			default: begin
				out_rows = '0;
				out_cols = '0;
			end
		endcase

		// source coordinate, only meaningful when in range
		case (cfg.mode)
			rgbfte_pkg::MODE_MIRROR: begin
				sr = row_x;
				sc = {1'b0, eff_w} - 11'd1 - col_x;
			end
			rgbfte_pkg::MODE_ROTATE: begin
				sr = col_x;
				sc = {1'b0, eff_w} - 11'd1 - row_x;
			end
			rgbfte_pkg::MODE_GROW: begin
				sr = row_x >> 1;
				sc = col_x >> 1;
			end
			rgbfte_pkg::MODE_SHRINK: begin
				sr = {row_pos, 1'b0};
				sc = {col_pos, 1'b0};
			end
			default: begin
				sr = row_x;
				sc = col_x;
			end
		endcase

		if (func == rgbfte_pkg::FUNC_LOAD) begin
			in_rng = (row_pos < eff_h) && (col_pos < eff_w);
			sr     = row_x;
			sc     = col_x;
		end else begin
			in_rng = (row_x < out_rows) && (col_x < out_cols);
		end

		idx = 32'(sr) * 32'(rgbfte_pkg::MAX_WIDTH) + 32'(sc);

		req.access = in_rng;
		req.we     = (func == rgbfte_pkg::FUNC_LOAD);
		req.oor    = !in_rng;
		req.addr   = idx[rgbfte_pkg::ADDR_W-1:0];
	end

endmodule

// ===== sv/rgbfte_pix.sv =====
module rgbfte_pix (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  rgbfte_pkg::ctl_t              ctl_s1,
	input  logic [rgbfte_pkg::PIX_W-1:0]  rdata,
	input  logic [15:0]                   max_value,
	output logic                          out_valid,
	output logic [15:0]                   red_out,
	output logic [15:0]                   green_out,
	output logic [15:0]                   blue_out,
	output logic                          out_of_range
);

	localparam int CB = rgbfte_pkg::CHANNEL_BITS;

	logic [15:0]                 px [3];
	logic [15:0]                 neg [3];
	rgbfte_pkg::ctl_t            ctl_s2;
	logic [15:0]                 px_s2 [3];
	logic [15:0]                 neg_s2 [3];
	logic [rgbfte_pkg::SUM_W-1:0] sum_s2;
	logic [rgbfte_pkg::PROD_W-1:0] prod;
	logic [15:0]                 avg;
	logic [15:0]                 res [3];
	logic                        valid_s3;
	logic [15:0]                 res_s3 [3];
	logic                        oor_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			px[k]  = 16'(rdata[k*CB +: CB]);
			neg[k] = (max_value > px[k]) ? (max_value - px[k]) : 16'd0;
		end
	end

	// stage 2: channel sum and negatives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				px_s2[k]  <= px[k];
				neg_s2[k] <= neg[k];
			end
			sum_s2 <= rgbfte_pkg::SUM_W'(rdata[0 +: CB])
				+ rgbfte_pkg::SUM_W'(rdata[CB +: CB])
				+ rgbfte_pkg::SUM_W'(rdata[2*CB +: CB]);
		end
	end

	// stage 3: divide by three via reciprocal, pick the mode result
	always_comb begin
		prod = rgbfte_pkg::PROD_W'(sum_s2)
			* rgbfte_pkg::PROD_W'(rgbfte_pkg::GRAY_RECIP);
		avg  = 16'(prod[rgbfte_pkg::GRAY_SHIFT +: CB]);
		for (int k = 0; k < 3; k++) begin
			if (!ctl_s2.read || ctl_s2.oor) begin
				res[k] = 16'd0;
			end else begin
				case (ctl_s2.mode)
					rgbfte_pkg::MODE_NEG:  res[k] = neg_s2[k];
					rgbfte_pkg::MODE_GRAY: res[k] = avg;
					default:               res[k] = px_s2[k];
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				res_s3[k] <= res[k];
			end
			oor_s3 <= ctl_s2.oor;
		end
	end

	assign out_valid    = valid_s3;
	assign red_out      = res_s3[0];
	assign green_out    = res_s3[1];
	assign blue_out     = res_s3[2];
	assign out_of_range = oor_s3;

endmodule

// ===== verif/pixel_xform_checker.sv =====
module pixel_xform_checker
	import rgbfte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [9:0]  row_pos,
	input  logic [9:0]  col_pos,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,

	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] red_out,
	input  logic [15:0] green_out,
	input  logic [15:0] blue_out,
	input  logic        out_of_range,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,

	output int          fail_cnt,
	output int          pending
);

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        oor;
	} pixel_res_t;

	pixel_res_t     expected_pixels [$];
	bit [PIX_W-1:0] frame_copy [DEPTH];

	logic [2:0]  mode_q;
	logic [9:0]  width_q;
	logic [9:0]  height_q;
	logic [15:0] maxval_q;
	int          result_no;

	initial begin
		fail_cnt  = 0;
		pending   = 0;
		result_no = 0;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (fail_cnt < 200) begin
			$display("[%0t] pixel %0d: %s got %0d want %0d", $time, result_no, what, got, want);
		end
		fail_cnt++;
	endtask

	// Applies one item to the private frame copy and returns the pixel it should produce.
	function automatic pixel_res_t predict_item(input logic f, input logic [9:0] r, c,
			input logic [15:0] ri, gi, bi);
		int          w, h, rows, cols, sr, sc, sum;
		logic [15:0] px [3];
		pixel_res_t  res;

		w   = (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
		h   = (height_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q);
		res = '0;

		if (f == FUNC_LOAD) begin
			if (r < h && c < w) begin
				frame_copy[r * MAX_WIDTH + c] = {ri, gi, bi};
			end else begin
				res.oor = 1'b1;
			end
			return res;
		end

		case (mode_q)
			MODE_NEG, MODE_GRAY, MODE_MIRROR: begin rows = h;           cols = w;           end
			MODE_ROTATE:                      begin rows = w;           cols = h;           end
			MODE_GROW:                        begin rows = 2 * h;       cols = 2 * w;       end
			MODE_SHRINK:                      begin rows = (h + 1) / 2; cols = (w + 1) / 2; end
			default:                          begin rows = 0;           cols = 0;           end
		endcase

		if (r >= rows || c >= cols) begin
			res.oor = 1'b1;
			return res;
		end

		case (mode_q)
			MODE_MIRROR: begin sr = r;     sc = w - 1 - c; end
			MODE_ROTATE: begin sr = c;     sc = w - 1 - r; end
			MODE_GROW:   begin sr = r / 2; sc = c / 2;     end
			MODE_SHRINK: begin sr = 2 * r; sc = 2 * c;     end
			default:     begin sr = r;     sc = c;         end
		endcase

		{px[0], px[1], px[2]} = frame_copy[sr * MAX_WIDTH + sc];

		case (mode_q)
			MODE_NEG: begin
				res.red   = (maxval_q > px[0]) ? maxval_q - px[0] : '0;
				res.green = (maxval_q > px[1]) ? maxval_q - px[1] : '0;
				res.blue  = (maxval_q > px[2]) ? maxval_q - px[2] : '0;
			end
			MODE_GRAY: begin
				sum       = px[0] + px[1] + px[2];
				res.red   = 16'(sum / 3);
				res.green = res.red;
				res.blue  = res.red;
			end
			default: begin
				res.red   = px[0];
				res.green = px[1];
				res.blue  = px[2];
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_res_t want;
		if (!arst_n) begin
			expected_pixels.delete();
			mode_q   = MODE_NEG;
			width_q  = 10'(MAX_WIDTH);
			height_q = 10'(MAX_HEIGHT);
			maxval_q = 16'd255;
			pending  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					flag_mismatch("pixel with none outstanding, red", red_out, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (red_out !== want.red)
						flag_mismatch("red_out", red_out, want.red);
					if (green_out !== want.green)
						flag_mismatch("green_out", green_out, want.green);
					if (blue_out !== want.blue)
						flag_mismatch("blue_out", blue_out, want.blue);
					if (out_of_range !== want.oor)
						flag_mismatch("out_of_range", out_of_range, want.oor);
				end
				result_no++;
			end

			if (in_valid && in_ready) begin
				expected_pixels.push_back(predict_item(func, row_pos, col_pos,
					red_in, green_in, blue_in));
			end

			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MODE:   mode_q   = pwdata[2:0];
					REG_WIDTH:  width_q  = pwdata[9:0];
					REG_HEIGHT: height_q = pwdata[9:0];
					REG_MAXVAL: maxval_q = pwdata[15:0];
					default: ;
				endcase
			end

			pending = expected_pixels.size();
		end
	end

endmodule

// ===== verif/rgb_frame_transform_engine_core_tb.sv =====
module rgb_frame_transform_engine_core_tb;
	import rgbfte_pkg::*;

	// Generous ceiling: under a thousand items, each seeing a long sender gap,
	// a long receiver stall and the pipeline depth, still sits far below this.
	localparam int CYCLE_LIMIT = 1_000_000;

	// Mode codes the block leaves unused; reads there must come back out of range.
	localparam logic [2:0] MODE_SPARE_LO = MODE_SHRINK + 3'd1;
	localparam logic [2:0] MODE_SPARE_HI = MODE_SHRINK + 3'd2;

	logic        clk = 1'b0;
	logic        arst_n;

	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [9:0]  row_pos;
	logic [9:0]  col_pos;
	logic [15:0] red_in;
	logic [15:0] green_in;
	logic [15:0] blue_in;

	logic        out_valid;
	logic        out_ready;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic        out_of_range;

	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_cnt;
	int pending;

	// Item bookkeeping: accepted on the input side versus delivered on the output side.
	int sent_cnt  = 0;
	int done_cnt  = 0;
	int cycle_cnt = 0;
	int calm_left = 0;

	// Our view of the current setting, used only to steer stimulus: output image
	// size for picking coordinates, and which source pixel a read will touch.
	logic [2:0] cur_mode = MODE_NEG;
	int         cur_w    = MAX_WIDTH;
	int         cur_h    = MAX_HEIGHT;

	// Source pixels loaded since the run began. The store is never cleared, so a
	// read may only land on an entry marked here.
	bit loaded [DEPTH];

	rgb_frame_transform_engine_core u_dut (.*);

	pixel_xform_checker u_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			done_cnt <= done_cnt + 1;
	end

	// Receiver back-pressure: mostly short stalls, now and then a long one, and
	// occasional long stretches of uninterrupted acceptance.
	initial begin
		int stall, run, pick;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 19);
			if (pick < 6)
				stall = 0;
			else if (pick < 17)
				stall = $urandom_range(1, 3);
			else
				stall = $urandom_range(4, 30);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	// Sender gap before the next item; calm stretches force back-to-back items.
	task automatic pick_gap(output int n);
		int pick;
		if (calm_left > 0) begin
			calm_left--;
			n = 0;
			return;
		end
		if ($urandom_range(0, 19) == 0)
			calm_left = $urandom_range(10, 50);
		pick = $urandom_range(0, 99);
		if (pick < 50)
			n = 0;
		else if (pick < 85)
			n = $urandom_range(1, 3);
		else if (pick < 97)
			n = $urandom_range(4, 10);
		else
			n = $urandom_range(11, 40);
	endtask

	function automatic logic [15:0] pick_chan();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(0, 511));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void out_size(output int rows, output int cols);
		case (cur_mode)
			MODE_NEG, MODE_GRAY, MODE_MIRROR: begin rows = cur_h; cols = cur_w; end
			MODE_ROTATE: begin rows = cur_w;           cols = cur_h;           end
			MODE_GROW:   begin rows = 2 * cur_h;       cols = 2 * cur_w;       end
			MODE_SHRINK: begin rows = (cur_h + 1) / 2; cols = (cur_w + 1) / 2; end
			default:     begin rows = 0;               cols = 0;               end
		endcase
	endfunction

	// Which store entry a read at (r, c) will fetch; zero when it fetches none.
	function automatic bit source_of(input int r, input int c, output int idx);
		int rows, cols, sr, sc;
		out_size(rows, cols);
		idx = 0;
		if (r >= rows || c >= cols)
			return 1'b0;
		case (cur_mode)
			MODE_MIRROR: begin sr = r;     sc = cur_w - 1 - c; end
			MODE_ROTATE: begin sr = c;     sc = cur_w - 1 - r; end
			MODE_GROW:   begin sr = r / 2; sc = c / 2;         end
			MODE_SHRINK: begin sr = 2 * r; sc = 2 * c;         end
			default:     begin sr = r;     sc = c;             end
		endcase
		idx = sr * MAX_WIDTH + sc;
		return 1'b1;
	endfunction

	// One item on the input channel; returns at the edge it was accepted.
	task automatic send_item(input logic f, input int r, input int c,
			input logic [15:0] rv, input logic [15:0] gv, input logic [15:0] bv);
		int gap;
		pick_gap(gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		row_pos  <= 10'(r);
		col_pos  <= 10'(c);
		red_in   <= rv;
		green_in <= gv;
		blue_in  <= bv;
		do @(posedge clk); while (!in_ready);
		sent_cnt++;
	endtask

	task automatic load_at(input int r, input int c,
			input logic [15:0] rv, input logic [15:0] gv, input logic [15:0] bv);
		send_item(FUNC_LOAD, r, c, rv, gv, bv);
		if (r < cur_h && c < cur_w)
			loaded[r * MAX_WIDTH + c] = 1'b1;
	endtask

	task automatic load_px(input int r, input int c);
		load_at(r, c, pick_chan(), pick_chan(), pick_chan());
	endtask

	// A read whose source pixel has never been loaded gets that pixel loaded first.
	// Channel inputs on a read are don't-care, so they carry noise.
	task automatic read_px(input int r, input int c);
		int idx;
		if (source_of(r, c, idx) && !loaded[idx])
			load_px(idx / MAX_WIDTH, idx % MAX_WIDTH);
		send_item(FUNC_READ, r, c, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Drain: input idle until every accepted item has produced its pixel.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (done_cnt < sent_cnt) @(posedge clk);
	endtask

	// APB write: setup phase, access phase, then an idle phase so that psel
	// is never dropped and raised in the same step.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Only reached with the block drained.
	task automatic set_config(input logic [2:0] m, input int w, input int h, input int mv);
		settle();
		write_reg(REG_MODE, 32'(m));
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
		write_reg(REG_MAXVAL, 32'(mv));
		cur_mode = m;
		cur_w    = (w > MAX_WIDTH) ? MAX_WIDTH : w;
		cur_h    = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
	endtask

	// Image dimension: mostly tiny so whole frames get loaded, sometimes large,
	// rarely zero or beyond the store (which must saturate).
	function automatic int pick_dim();
		int pick;
		pick = $urandom_range(0, 39);
		if (pick == 0)
			return 0;
		else if (pick == 1)
			return $urandom_range(MAX_WIDTH + 1, 1023);
		else if (pick == 2)
			return MAX_WIDTH;
		else if (pick <= 5)
			return $urandom_range(13, MAX_WIDTH);
		else
			return $urandom_range(1, 12);
	endfunction

	task automatic new_setting();
		logic [2:0] m;
		int         mv, pick;
		if ($urandom_range(0, 19) == 0)
			m = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
		else
			m = 3'($urandom_range(MODE_NEG, MODE_SHRINK));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			mv = 0;
		else if (pick == 1)
			mv = 16'hFFFF;
		else if (pick <= 4)
			mv = $urandom_range(0, 16'hFFFF);
		else
			mv = $urandom_range(1, 1023);
		set_config(m, pick_dim(), pick_dim(), mv);
	endtask

	initial begin : stimulus
		int base, n, op, rows, cols;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		func     = FUNC_LOAD;
		row_pos  = '0;
		col_pos  = '0;
		red_in   = '0;
		green_in = '0;
		blue_in  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset setting first (negative, full size, max 255), with corner
		// pixels, saturation below zero and loads off the edge of the source.
		load_at(0, 0, 16'h0000, 16'd255, 16'hFFFF);
		load_at(MAX_HEIGHT - 1, MAX_WIDTH - 1, 16'hFFFF, 16'd254, 16'h0000);
		load_at(0, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		load_at(1023, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		read_px(0, 0);
		read_px(MAX_HEIGHT - 1, MAX_WIDTH - 1);
		read_px(MAX_HEIGHT, 0);

		// Gray on the largest possible sum, and negative against the top max value
		set_config(MODE_GRAY, MAX_WIDTH, MAX_HEIGHT, 16'hFFFF);
		load_at(5, 5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		read_px(5, 5);
		read_px(0, 0);
		set_config(MODE_NEG, MAX_WIDTH, MAX_HEIGHT, 16'hFFFF);
		read_px(5, 5);

		// Geometry at the corners of each transform
		set_config(MODE_MIRROR, MAX_WIDTH, MAX_HEIGHT, 255);
		read_px(0, MAX_WIDTH - 1);
		read_px(MAX_HEIGHT - 1, 0);
		set_config(MODE_ROTATE, MAX_WIDTH, MAX_HEIGHT, 255);
		read_px(MAX_WIDTH - 1, 0);
		read_px(0, MAX_HEIGHT - 1);
		set_config(MODE_GROW, MAX_WIDTH, MAX_HEIGHT, 255);
		read_px(1023, 1023);
		read_px(1, 1);
		set_config(MODE_SHRINK, MAX_WIDTH, MAX_HEIGHT, 255);
		read_px(MAX_HEIGHT / 2 - 1, MAX_WIDTH / 2 - 1);
		read_px(MAX_HEIGHT / 2, 0);

		// Unused modes
		set_config(MODE_SPARE_LO, MAX_WIDTH, MAX_HEIGHT, 255);
		read_px(0, 0);
		set_config(MODE_SPARE_HI, MAX_WIDTH, MAX_HEIGHT, 255);
		read_px(0, 0);

		// Zero width: everything out of range. Oversized width saturates.
		set_config(MODE_NEG, 0, 4, 255);
		load_at(0, 0, 16'h1234, 16'h5678, 16'h9ABC);
		read_px(0, 0);
		set_config(MODE_MIRROR, 1023, 1, 1000);
		load_at(0, MAX_WIDTH - 1, 16'hAAAA, 16'h5555, 16'h0F0F);
		load_at(1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		read_px(0, 0);

		// Random phases: new setting, often a whole small frame loaded, then a mix
		// of in-range reads, stray reads and fresh or stray loads.
		base = sent_cnt;
		while (sent_cnt - base < 800) begin
			new_setting();
			out_size(rows, cols);
			if (cur_w * cur_h > 0 && cur_w * cur_h <= 64 && $urandom_range(0, 2) != 0) begin
				for (int rr = 0; rr < cur_h; rr++)
					for (int cc = 0; cc < cur_w; cc++)
						load_px(rr, cc);
			end
			n = $urandom_range(15, 50);
			repeat (n) begin
				op = $urandom_range(0, 9);
				if (op == 0 && cur_w * cur_h > 0)
					load_px($urandom_range(0, cur_h - 1), $urandom_range(0, cur_w - 1));
				else if (op <= 1)
					load_px($urandom_range(0, 1023), $urandom_range(0, 1023));
				else if (op == 2 || rows == 0 || cols == 0)
					read_px($urandom_range(0, 1023), $urandom_range(0, 1023));
				else
					read_px($urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rgbfte_pkg.sv
sv/rgbfte_ram.sv
sv/rgbfte_addr.sv
sv/rgbfte_pix.sv
sv/rgbfte_top.sv
verif/pixel_xform_checker.sv
verif/rgb_frame_transform_engine_core_tb.sv
